### rtl/lbo_pkg.sv
// ---------------------------------------------------------------------------
// lbo_pkg
// Shared types, constants and arithmetic helpers for the lane boundary block.
// ---------------------------------------------------------------------------
package lbo_pkg;

    localparam int MAX_LANES    = 16;
    localparam int MAX_SEGMENTS = 8;
    localparam int LANE_W       = $clog2(MAX_LANES);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int NCNT_W       = $clog2(MAX_LANES + 1);

    // configuration register indexes
    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic signed [31:0] off;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } t_seg;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       sat34 = 32'sh7fffffff;
        else if (v < -34'sd2147483648) sat34 = 32'sh80000000;
        else                           sat34 = v[31:0];
    endfunction

    // round a Q32.32 product to Q16.16 (nearest, ties up) and add a coefficient
    function automatic logic signed [31:0] rnd_add(input logic signed [63:0] p,
                                                  input logic signed [31:0] c);
        logic signed [64:0] q;
        logic signed [49:0] r;
        logic signed [50:0] s;
        q = {p[63], p} + 65'sd32768;
        r = {q[64], q[64:16]};
        s = {r[49], r} + 51'(c);
        if (s > 51'sd2147483647)       rnd_add = 32'sh7fffffff;
        else if (s < -51'sd2147483648) rnd_add = 32'sh80000000;
        else                           rnd_add = s[31:0];
    endfunction

endpackage

### rtl/lane_boundary_offsets_core.sv
// ---------------------------------------------------------------------------
// lane_boundary_offsets_core
// Lateral lane boundary positions from piecewise cubic lane widths.
// ---------------------------------------------------------------------------
// A load beat is taken while idle and gives no output. A sample beat starts
// all lane cells at once; each cell scans its segments (one compare per cycle,
// up to 8 segments) and then runs three steps, each a multiply and then a round
// and add; the block waits for the slowest cell. Boundaries are then
// accumulated from the reference boundary (set by the left register) outward,
// first leftward and then rightward, one lane per cycle, and emitted left to
// right, one beat per cycle while the sink is ready. The input is not ready
// for the next beat until the sink has taken the last boundary of a sample.
module lane_boundary_offsets_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_command,
    input  logic [3:0]                  i_lane_index,
    input  logic [2:0]                  i_segment_index,
    input  logic                        i_last_segment,
    input  logic signed [31:0]          i_seg_offset,
    input  logic signed [31:0]          i_coef_a,
    input  logic signed [31:0]          i_coef_b,
    input  logic signed [31:0]          i_coef_c,
    input  logic signed [31:0]          i_coef_d,
    input  logic signed [31:0]          i_s_coord,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [4:0]                  o_boundary_index,
    output logic signed [31:0]          o_lateral,
    output logic                        o_last
);
    import lbo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WAIT = 5'b00010,
        S_LEFT = 5'b00100,
        S_RGHT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state;
    logic [4:0]          r_left_cfg, r_cnt_cfg;
    logic signed [31:0]  r_start;
    logic [NCNT_W-1:0]   r_n, r_left, r_k;
    logic signed [31:0]  r_pos [MAX_LANES+1];
    logic signed [31:0]  w_width [MAX_LANES];
    logic [MAX_LANES-1:0] w_done, w_load;
    logic                w_start, w_acc;
    logic signed [31:0]  w_param;
    t_seg                w_seg;
    logic [NCNT_W-1:0]   w_n;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_start = w_acc && (i_command == CMD_SAMPLE);
    assign w_param = sat34(34'(i_s_coord) - 34'(r_start));
    assign w_seg   = '{off: i_seg_offset, a: i_coef_a, b: i_coef_b,
                       c: i_coef_c, d: i_coef_d};
    assign w_n     = (r_cnt_cfg > 5'(MAX_LANES)) ? NCNT_W'(MAX_LANES)
                                                 : NCNT_W'(r_cnt_cfg);

    // row of lane cells
    for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
        assign w_load[g] = w_acc && (i_command == CMD_LOAD) &&
                           (i_lane_index == LANE_W'(g));
        lbo_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_load[g]),
            .i_seg_idx  (i_segment_index),
            .i_last_seg (i_last_segment),
            .i_seg      (w_seg),
            .i_start    (w_start),
            .i_param    (w_param),
            .o_done     (w_done[g]),
            .o_width    (w_width[g])
        );
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cfg <= '0;
            r_cnt_cfg  <= '0;
            r_start    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT:  r_left_cfg <= i_cfg_data[4:0];
                REG_COUNT: r_cnt_cfg  <= i_cfg_data[4:0];
                REG_START: r_start    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // boundary accumulation and output sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_n     <= w_n;
                        r_left  <= (NCNT_W'(r_left_cfg) > w_n) ? w_n
                                                               : NCNT_W'(r_left_cfg);
                        r_state <= S_WAIT;
                    end
                end
                // wait for every lane cell
                S_WAIT: begin
                    if (&w_done) begin
                        r_pos[r_left[LANE_W:0]] <= '0;
                        r_k     <= r_left;
                        r_state <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    if (r_k == '0) begin
                        r_k     <= r_left;
                        r_state <= S_RGHT;
                    end else begin
                        r_pos[r_k - NCNT_W'(1)] <= sat34(34'(r_pos[r_k]) +
                            34'(w_width[r_k[LANE_W-1:0] - LANE_W'(1)]));
                        r_k <= r_k - NCNT_W'(1);
                    end
                end
                S_RGHT: begin
                    if (r_k >= r_n) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_pos[r_k + NCNT_W'(1)] <= sat34(34'(r_pos[r_k]) -
                            34'(w_width[r_k[LANE_W-1:0]]));
                        r_k <= r_k + NCNT_W'(1);
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_k == r_n) r_state <= S_IDLE;
                        r_k <= r_k + NCNT_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = (r_state == S_OUT);
    assign o_boundary_index = 5'(r_k);
    assign o_lateral        = r_pos[r_k];
    assign o_last           = (r_k == r_n);
endmodule

### rtl/lbo_cell.sv
// ---------------------------------------------------------------------------
// lbo_cell
// One lane cell: holds the lane's segment count and segments, picks the
// segment for a parameter and evaluates its width by Horner's rule, each
// step a multiply then a round and add; the scan passes the segment table.
// ---------------------------------------------------------------------------
module lbo_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [lbo_pkg::SEG_W-1:0]  i_seg_idx,
    input  logic                       i_last_seg,
    input  lbo_pkg::t_seg              i_seg,
    input  logic                       i_start,
    input  logic signed [31:0]         i_param,
    output logic                       o_done,
    output logic signed [31:0]         o_width
);
    import lbo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_seg               r_store [MAX_SEGMENTS];
    logic [CNT_W-1:0]   r_cnt;
    t_state             r_state;
    logic [CNT_W-1:0]   r_i;
    logic [1:0]         r_step;
    logic signed [31:0] r_acc, r_ds, r_param;
    logic signed [63:0] r_prod;
    logic               r_mulph;
    t_seg               w_sel, w_nxt;

    assign w_sel = r_store[r_i[SEG_W-1:0] - SEG_W'(1)];
    assign w_nxt = r_store[r_i[SEG_W-1:0]];

    // segment storage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_store[i_seg_idx] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_state <= S_IDLE;
            r_i     <= '0;
            r_step  <= '0;
            r_mulph <= 1'b0;
        end else begin
            if (i_load && i_last_seg) r_cnt <= CNT_W'(i_seg_idx) + CNT_W'(1);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_param <= i_param;
                        r_i     <= CNT_W'(1);
                        if (r_cnt == '0) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // one segment compare per cycle
                S_SCAN: begin
                    if (r_i >= r_cnt || r_param < w_nxt.off) begin
                        r_ds    <= sat34(34'(r_param) - 34'(w_sel.off));
                        r_acc   <= w_sel.d;
                        r_step  <= '0;
                        r_mulph <= 1'b0;
                        r_state <= S_EVAL;
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                // multiply, then round and add
                S_EVAL: begin
                    if (!r_mulph) begin
                        r_prod  <= r_acc * r_ds;
                        r_mulph <= 1'b1;
                    end else begin
                        r_mulph <= 1'b0;
                        case (r_step)
                            2'd0: r_acc <= rnd_add(r_prod, w_sel.c);
                            2'd1: r_acc <= rnd_add(r_prod, w_sel.b);
                            default: r_acc <= rnd_add(r_prod, w_sel.a);
                        endcase
                        r_step <= r_step + 2'd1;
                        if (r_step == 2'd2) r_state <= S_DONE;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // width is held until the next start, so done stays high once reached
    assign o_done  = (r_state == S_DONE) || (r_state == S_IDLE);
    assign o_width = r_acc;
endmodule

### verif/tb_lane_boundary_offsets_core.sv
// ---------------------------------------------------------------------------
// tb_lane_boundary_offsets_core
// Self-checking bench: random load and sample beats against an internal
// predictor of the piecewise cubic lane widths and boundary accumulation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lane_boundary_offsets_core;
    import lbo_pkg::*;

    typedef struct {
        logic               cmd;
        logic [3:0]         lane;
        logic [2:0]         seg;
        logic               lastseg;
        logic signed [31:0] off, a, b, c, d, s;
    } t_item;

    typedef struct {
        logic [4:0]         idx;
        logic signed [31:0] lat;
        logic               lst;
    } t_bound;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = REG_LEFT;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0, o_ready, i_command = CMD_LOAD;
    logic [3:0] i_lane_index = '0;
    logic [2:0] i_segment_index = '0;
    logic i_last_segment = 1'b0;
    logic signed [31:0] i_seg_offset = '0, i_coef_a = '0, i_coef_b = '0;
    logic signed [31:0] i_coef_c = '0, i_coef_d = '0, i_s_coord = '0;
    logic o_valid, i_ready = 1'b0, o_last;
    logic [4:0] o_boundary_index;
    logic signed [31:0] o_lateral;

    lane_boundary_offsets_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_seg         seg_tab [MAX_LANES][MAX_SEGMENTS];
    bit           seg_written [MAX_LANES][MAX_SEGMENTS];
    int unsigned  seg_cnt [MAX_LANES];
    int unsigned  left_cfg, lanes_cfg;
    longint       start_cfg;

    t_item  pending_beats[$];
    t_bound expected_bounds[$];
    int     errors = 0;
    bit     calm = 1'b0;
    int     busy_pct = 30;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // nearest, ties upward, on a Q32.32 product
    function automatic longint q_round(longint p);
        longint q = p + 32768;
        return q >>> 16;
    endfunction

    function automatic longint width_of(int lane, longint param);
        int unsigned n = seg_cnt[lane];
        int i;
        longint ds, acc;
        t_seg sg;
        if (n == 0) return 0;
        for (i = 1; i < n; i++)
            if (param < longint'(seg_tab[lane][i].off)) break;
        sg = seg_tab[lane][i-1];
        ds  = sat(param - longint'(sg.off));
        acc = sg.d;
        acc = sat(q_round(acc * ds) + sg.c);
        acc = sat(q_round(acc * ds) + sg.b);
        acc = sat(q_round(acc * ds) + sg.a);
        return acc;
    endfunction

    function automatic void predict_beat(t_item it);
        longint pos [MAX_LANES+1];
        int unsigned n, lft;
        longint param;
        t_bound bd;
        if (it.cmd == CMD_LOAD) begin
            seg_tab[it.lane][it.seg] = '{it.off, it.a, it.b, it.c, it.d};
            seg_written[it.lane][it.seg] = 1'b1;
            if (it.lastseg) seg_cnt[it.lane] = it.seg + 1;
            return;
        end
        n = (lanes_cfg > MAX_LANES) ? MAX_LANES : lanes_cfg;
        lft = (left_cfg > n) ? n : left_cfg;
        param = sat(longint'(it.s) - start_cfg);
        pos[lft] = 0;
        for (int i = lft; i > 0; i--) pos[i-1] = sat(pos[i] + width_of(i-1, param));
        for (int i = lft; i < n; i++) pos[i+1] = sat(pos[i] - width_of(i, param));
        for (int i = 0; i <= n; i++) begin
            bd.idx = i[4:0];
            bd.lat = pos[i][31:0];
            bd.lst = (i == n);
            expected_bounds.push_back(bd);
        end
    endfunction

    // acceptance of the last beat, seen at the rising edge
    logic o_ready_q = 1'b0;
    always @(posedge i_clk) o_ready_q <= i_valid && o_ready;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_q) begin
                if (pending_beats.size() > 0 &&
                    (calm || $urandom_range(99) >= busy_pct)) begin
                    t_item it;
                    it = pending_beats.pop_front();
                    i_valid <= 1'b1;
                    i_command <= it.cmd; i_lane_index <= it.lane;
                    i_segment_index <= it.seg; i_last_segment <= it.lastseg;
                    i_seg_offset <= it.off; i_coef_a <= it.a; i_coef_b <= it.b;
                    i_coef_c <= it.c; i_coef_d <= it.d; i_s_coord <= it.s;
                    predict_beat(it);
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= calm || ($urandom_range(99) >= busy_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bounds.size() == 0) begin
                $error("unexpected boundary beat idx=%0d", o_boundary_index);
                errors++;
            end else begin
                t_bound e;
                e = expected_bounds.pop_front();
                if (o_boundary_index !== e.idx) begin
                    $error("boundary_index exp %0d got %0d", e.idx, o_boundary_index);
                    errors++;
                end
                if (o_lateral !== e.lat) begin
                    $error("lateral exp %0d got %0d", e.lat, o_lateral);
                    errors++;
                end
                if (o_last !== e.lst) begin
                    $error("last exp %0d got %0d", e.lst, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rnd_val(int mode);
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(2 * mode)) - mode;
        endcase
    endfunction

    function automatic t_item mk_load(int lane, int sg, bit lst);
        t_item it;
        it.cmd = CMD_LOAD; it.lane = 4'(lane); it.seg = 3'(sg); it.lastseg = lst;
        it.off = (sg == 0) ? $signed($urandom_range(65536)) - 32768
                           : sg * 32'sh0004_0000 + $signed($urandom_range(65535));
        it.a = $signed($urandom_range(32'h0008_0000));
        it.b = $signed($urandom_range(8192)) - 4096;
        it.c = $signed($urandom_range(512)) - 256;
        it.d = $signed($urandom_range(64)) - 32;
        if ($urandom_range(9) == 0) it.a = rnd_val(1 << 20);
        if ($urandom_range(9) == 0) it.d = rnd_val(1 << 20);
        it.s = $urandom;
        return it;
    endfunction

    function automatic t_item mk_sample(logic signed [31:0] s);
        t_item it;
        it = mk_load($urandom_range(15), $urandom_range(7), 1'($urandom_range(1)));
        it.off = $urandom; it.a = $urandom; it.b = $urandom;
        it.c = $urandom; it.d = $urandom;
        it.cmd = CMD_SAMPLE; it.s = s;
        return it;
    endfunction

    // full load of one lane with nsegs segments, in segment order
    task automatic load_lane(int lane, int nsegs);
        for (int k = 0; k < nsegs; k++)
            pending_beats.push_back(mk_load(lane, k, k == nsegs - 1));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || i_valid || expected_bounds.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LEFT:  left_cfg = val[4:0];
            REG_COUNT: lanes_cfg = val[4:0];
            default:   start_cfg = longint'($signed(val));
        endcase
    endtask

    function automatic logic signed [31:0] rnd_s();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(32'h0024_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    initial begin
        for (int l = 0; l < MAX_LANES; l++) seg_cnt[l] = 0;
        left_cfg = 0; lanes_cfg = 0; start_cfg = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: empty table, zero lanes, then every lane loaded
        pending_beats.push_back(mk_sample(32'sh0));
        wait_drained();
        cfg_write(REG_COUNT, 5'd16);
        cfg_write(REG_LEFT, 5'd31);
        cfg_write(REG_START, 32'sh0);
        pending_beats.push_back(mk_sample(32'sh0001_0000)); // all lanes empty
        for (int l = 0; l < MAX_LANES; l++) load_lane(l, (l % 8) + 1);
        pending_beats.push_back(mk_sample(32'sh8000_0000));
        pending_beats.push_back(mk_sample(32'sh7fff_ffff));
        pending_beats.push_back(mk_sample(32'sh0000_0000));
        pending_beats.push_back(mk_sample(32'sh0008_0000));
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph == 3);
            cfg_write(REG_COUNT, (ph == 0) ? 5'd31 : (ph == 1) ? 5'd0 : $urandom_range(31));
            cfg_write(REG_LEFT, (ph == 2) ? 5'd0 : $urandom_range(31));
            cfg_write(REG_START, (ph == 4) ? 32'h8000_0000 :
                                 (ph == 5) ? 32'h7fff_ffff :
                                 $signed($urandom_range(32'h0004_0000)) - 32'sh2_0000);
            for (int k = 0; k < 22; k++) begin
                if ($urandom_range(3) == 0) begin
                    int l;
                    l = $urandom_range(15);
                    if ($urandom_range(1)) load_lane(l, $urandom_range(1, 8));
                    else begin
                        // rewrite within the loaded range, or declare a count
                        int n;
                        int sg;
                        bit ok;
                        n = seg_cnt[l];
                        sg = $urandom_range(7);
                        ok = 1'b1;
                        for (int j = 0; j <= sg; j++) ok &= seg_written[l][j];
                        if (ok)
                            pending_beats.push_back(mk_load(l, sg, 1'($urandom_range(1))));
                        else if (n > 0)
                            pending_beats.push_back(mk_load(l, $urandom_range(n - 1), 1'b0));
                    end
                end
                pending_beats.push_back(mk_sample(rnd_s()));
                if (k == 10 && ph == 6) wait_drained(); // sender holds off
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

### lane_boundary_offsets_core.f
rtl/lbo_pkg.sv
rtl/lbo_cell.sv
rtl/lane_boundary_offsets_core.sv
verif/tb_lane_boundary_offsets_core.sv
